>>> hdl/rij_pkg.sv
// Shared constants and types for the record intersection join.
// Holds table sizing, request codes and the stored record layout.
// No dependencies.
`default_nettype none

package rij_pkg;

   // Table capacity in records
   localparam int TABLE_DEPTH = 32;

   // Entry index and fill count widths
   localparam int IDX_WIDTH = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(TABLE_DEPTH + 1);

   localparam int WORD_WIDTH = 32;

   // Request codes
   localparam logic [1:0] REQ_CLEAR  = 2'd0;
   localparam logic [1:0] REQ_APPEND = 2'd1;
   localparam logic [1:0] REQ_PROBE  = 2'd2;

   // One stored record
   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] id;
      logic signed [WORD_WIDTH-1:0] first_value;
      logic signed [WORD_WIDTH-1:0] second_value;
   } record_type;

   localparam int RECORD_WIDTH = $bits(record_type);

endpackage

`default_nettype wire

>>> hdl/rij_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Self-contained; no package dependency.
`default_nettype none

module rij_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                        clock,
   input  wire logic                                        wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                            wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                            rd_data_ff
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> hdl/record_intersection_join.sv
// Record intersection join: stored table plus probe scan engine.
// Depends on rij_pkg and rij_ram.
//
// Usage
//  - Input channel (req_valid/req_ready) carries requests: clear the table,
//    append a record, or probe with a record. req_ready is high only while
//    the engine is idle; clear and append complete in the accepting cycle.
//  - A probe walks the table in stored order, one entry read per cycle while
//    it is not emitting, from a single RAM with registered read data. Each
//    matching entry yields two results on rsp_: the probe record, then the
//    stored record. The final result of a probe carries rsp_out_last.
//  - One match is held back until the next match or the end of the scan so
//    that the last result can be flagged.
//  - Results sit in an output register; the next request is accepted while
//    the last result of a probe still waits. When rsp_ready is low the scan
//    stalls only when it needs to emit.
//  - csr_write_enable/csr_write_data set compare_field (0: first value,
//    1: second value). Write them only while idle; the block does not check it.
//  - Synchronous reset empties the table and clears compare_field; the RAM
//    needs no clearing pass since entries past the fill count are never read.
`default_nettype none

module record_intersection_join (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   // request channel
   input  wire logic                                    req_valid,
   output logic                                         req_ready,
   input  wire logic [1:0]                              req_type,
   input  wire logic signed [rij_pkg::WORD_WIDTH-1:0]   req_in_id,
   input  wire logic signed [rij_pkg::WORD_WIDTH-1:0]   req_in_first_value,
   input  wire logic signed [rij_pkg::WORD_WIDTH-1:0]   req_in_second_value,
   // result channel
   output logic                                         rsp_valid,
   input  wire logic                                    rsp_ready,
   output logic signed [rij_pkg::WORD_WIDTH-1:0]        rsp_out_id,
   output logic signed [rij_pkg::WORD_WIDTH-1:0]        rsp_out_first_value,
   output logic signed [rij_pkg::WORD_WIDTH-1:0]        rsp_out_second_value,
   output logic                                         rsp_out_from_table,
   output logic                                         rsp_out_last,
   // configuration
   input  wire logic                                    csr_write_enable,
   input  wire logic                                    csr_write_data
);

   import rij_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_EMIT_PROBE,
      ST_EMIT_TABLE
   } state_type;

   state_type              state_ff;
   logic                   compare_field_ff;
   logic [CNT_WIDTH-1:0]   count_ff;
   logic [IDX_WIDTH-1:0]   idx_ff;
   record_type             probe_ff;
   record_type             held_ff;
   logic                   held_valid_ff;
   record_type             cand_ff;
   logic                   final_ff;

   logic                   rsp_valid_ff;
   record_type             rsp_rec_ff;
   logic                   rsp_from_table_ff;
   logic                   rsp_last_ff;

   logic                   req_xfer;
   logic                   out_free;
   logic                   rsp_load;
   logic                   hit;
   logic                   more;
   logic [CNT_WIDTH-1:0]   idx_next_cnt;
   logic [IDX_WIDTH-1:0]   rd_addr;
   logic                   wr_en;
   record_type             wr_rec;
   logic [RECORD_WIDTH-1:0] rd_data;
   record_type             rd_rec;

   // Table storage
   rij_ram #(
      .WIDTH (RECORD_WIDTH),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock      (clock),
      .wr_en      (wr_en),
      .wr_addr    (count_ff[IDX_WIDTH-1:0]),
      .wr_data    (wr_rec),
      .rd_addr    (rd_addr),
      .rd_data_ff (rd_data)
   );

   assign rd_rec = record_type'(rd_data);

   // Handshake and scan control terms
   assign req_ready    = (state_ff == ST_IDLE);
   assign req_xfer     = req_valid && req_ready;
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_load     = out_free && (state_ff inside {ST_EMIT_PROBE, ST_EMIT_TABLE});
   assign idx_next_cnt = CNT_WIDTH'(idx_ff) + CNT_WIDTH'(1);
   assign more         = (idx_next_cnt < count_ff);

   // Append when there is room
   assign wr_en  = req_xfer && (req_type == REQ_APPEND) &&
                   (count_ff < CNT_WIDTH'(TABLE_DEPTH));
   assign wr_rec = '{id: req_in_id, first_value: req_in_first_value,
                     second_value: req_in_second_value};

   // Compare the fetched entry with the probe
   always_comb begin
      hit = (rd_rec.id == probe_ff.id) &&
            (compare_field_ff ? (rd_rec.second_value == probe_ff.second_value)
                              : (rd_rec.first_value == probe_ff.first_value));
   end

   // Pick the read address: entry 0 at probe start, else the next entry
   always_comb begin
      if (state_ff == ST_IDLE) begin
         rd_addr = '0;
      end else begin
         rd_addr = idx_next_cnt[IDX_WIDTH-1:0];
      end
   end

   // State, table bookkeeping and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         compare_field_ff <= 1'b0;
         count_ff         <= '0;
         idx_ff           <= '0;
         held_valid_ff    <= 1'b0;
         final_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            compare_field_ff <= csr_write_data;
         end

         // drop the output once taken, unless a new one is loaded
         if (rsp_valid_ff && rsp_ready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_xfer) begin
                  if (req_type == REQ_CLEAR) begin
                     count_ff <= '0;
                  end else if (wr_en) begin
                     count_ff <= count_ff + CNT_WIDTH'(1);
                  end else if (req_type == REQ_PROBE && count_ff != '0) begin
                     probe_ff      <= wr_rec;
                     idx_ff        <= '0;
                     held_valid_ff <= 1'b0;
                     final_ff      <= 1'b0;
                     state_ff      <= ST_CHECK;
                  end
               end
            end

            ST_CHECK: begin
               if (hit && held_valid_ff) begin
                  // flush the held match, keep the new one aside
                  cand_ff  <= rd_rec;
                  final_ff <= 1'b0;
                  state_ff <= ST_EMIT_PROBE;
               end else begin
                  if (hit) begin
                     held_ff       <= rd_rec;
                     held_valid_ff <= 1'b1;
                  end
                  if (more) begin
                     idx_ff <= idx_next_cnt[IDX_WIDTH-1:0];
                  end else if (hit || held_valid_ff) begin
                     final_ff <= 1'b1;
                     state_ff <= ST_EMIT_PROBE;
                  end else begin
                     state_ff <= ST_IDLE;
                  end
               end
            end

            ST_EMIT_PROBE: begin
               if (out_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_rec_ff        <= probe_ff;
                  rsp_from_table_ff <= 1'b0;
                  rsp_last_ff       <= 1'b0;
                  state_ff          <= ST_EMIT_TABLE;
               end
            end

            ST_EMIT_TABLE: begin
               if (out_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_rec_ff        <= held_ff;
                  rsp_from_table_ff <= 1'b1;
                  rsp_last_ff       <= final_ff;
                  if (final_ff) begin
                     held_valid_ff <= 1'b0;
                     state_ff      <= ST_IDLE;
                  end else begin
                     held_ff <= cand_ff;
                     if (more) begin
                        // read for the next entry was issued this cycle
                        idx_ff   <= idx_next_cnt[IDX_WIDTH-1:0];
                        state_ff <= ST_CHECK;
                     end else begin
                        final_ff <= 1'b1;
                        state_ff <= ST_EMIT_PROBE;
                     end
                  end
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // Drive result ports
   assign rsp_valid            = rsp_valid_ff;
   assign rsp_out_id           = rsp_rec_ff.id;
   assign rsp_out_first_value  = rsp_rec_ff.first_value;
   assign rsp_out_second_value = rsp_rec_ff.second_value;
   assign rsp_out_from_table   = rsp_from_table_ff;
   assign rsp_out_last         = rsp_last_ff;

   // Fill count never passes capacity
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_WIDTH'(TABLE_DEPTH))
      else $error("table fill count exceeds capacity");

   // A probe-record result is never the last one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_from_table_ff) |-> !rsp_last_ff)
      else $error("probe record flagged as last");

   // A probe-record transfer is followed at once by its stored partner
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ready && !rsp_from_table_ff) |=>
      (rsp_valid_ff && rsp_from_table_ff))
      else $error("stored record did not follow probe record");

   // No request is taken while a scan is under way
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready)
      else $error("request accepted during scan");

endmodule

`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for record_intersection_join: a directed script, then random
// clear/append/probe traffic under several idle and stall mixes, checked against a local join.
// Depends on rij_pkg and the record_intersection_join RTL.

module tb;
   import rij_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int NO_CHECK = -1;
   localparam int SETTLE_CYCLES = TABLE_DEPTH + 8;
   localparam int DRAIN_LIMIT = 50000;
   localparam int RANDOM_PER_PHASE = 72;
   localparam int SCRIPT_LEN = 22;
   localparam logic signed [WORD_WIDTH-1:0] WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};
   localparam logic signed [WORD_WIDTH-1:0] WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic signed [WORD_WIDTH-1:0] WORD_ONES = '1;

   // One result transfer as seen on the rsp_ channel
   typedef struct packed {
      logic signed [WORD_WIDTH-1:0] id;
      logic signed [WORD_WIDTH-1:0] first_value;
      logic signed [WORD_WIDTH-1:0] second_value;
      logic                         from_table;
      logic                         last;
   } join_row_type;

   // Directed script row; a register write carries its value in rec.id[0]
   typedef struct {
      logic       is_csr;
      logic [1:0] kind;
      record_type rec;
      int         typed_hits;
   } script_step_type;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic [1:0]                   req_type;
   logic signed [WORD_WIDTH-1:0] req_in_id;
   logic signed [WORD_WIDTH-1:0] req_in_first_value;
   logic signed [WORD_WIDTH-1:0] req_in_second_value;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic signed [WORD_WIDTH-1:0] rsp_out_id;
   logic signed [WORD_WIDTH-1:0] rsp_out_first_value;
   logic signed [WORD_WIDTH-1:0] rsp_out_second_value;
   logic                         rsp_out_from_table;
   logic                         rsp_out_last;
   logic                         csr_write_enable;
   logic                         csr_write_data;

   // Local copy of the table and the compare mode
   record_type table_copy [TABLE_DEPTH];
   int         table_fill = 0;
   logic       match_on_second = 1'b0;

   join_row_type rows_due [$];
   int         mismatches = 0;
   int         rows_checked = 0;
   int         work_items = 0;
   int         probes_sent = 0;
   int         appends_sent = 0;
   int         clears_sent = 0;
   int         ignored_sent = 0;
   int         deepest_probe = 0;
   int         sender_idle_pct = 0;
   int         receiver_stall_pct = 0;

   record_intersection_join uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_in_id            (req_in_id),
      .req_in_first_value   (req_in_first_value),
      .req_in_second_value  (req_in_second_value),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_id           (rsp_out_id),
      .rsp_out_first_value  (rsp_out_first_value),
      .rsp_out_second_value (rsp_out_second_value),
      .rsp_out_from_table   (rsp_out_from_table),
      .rsp_out_last         (rsp_out_last),
      .csr_write_enable     (csr_write_enable),
      .csr_write_data       (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic join_row_type to_row(input record_type rec, input logic from_table,
                                           input logic last);
      return '{rec.id, rec.first_value, rec.second_value, from_table, last};
   endfunction

   function automatic string row_text(input join_row_type r);
      return $sformatf("id %h v1 %h v2 %h table %0b last %0b",
                       r.id, r.first_value, r.second_value, r.from_table, r.last);
   endfunction

   // Update the table copy for one request and list the results a probe yields
   function automatic void apply_request(input logic [1:0] kind, input record_type rec,
                                         ref join_row_type hits[$]);
      logic same_value;
      hits.delete();
      case (kind)
         REQ_CLEAR: table_fill = 0;
         REQ_APPEND: begin
            if (table_fill < TABLE_DEPTH) begin
               table_copy[table_fill] = rec;
               table_fill++;
            end
         end
         REQ_PROBE: begin
            for (int i = 0; i < table_fill; i++) begin
               same_value = match_on_second ?
                            (table_copy[i].second_value == rec.second_value) :
                            (table_copy[i].first_value == rec.first_value);
               if (table_copy[i].id == rec.id && same_value) begin
                  hits.push_back(to_row(rec, 1'b0, 1'b0));
                  hits.push_back(to_row(table_copy[i], 1'b1, 1'b0));
               end
            end
            if (hits.size() != 0) hits[hits.size()-1].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   // Mostly corner words so that ids and values collide, now and then a random one
   function automatic logic signed [WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(7))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return WORD_ONES;
         4: return 1;
         5: return 2;
         default: return $urandom;
      endcase
   endfunction

   function automatic record_type pick_record();
      return '{pick_word(), pick_word(), pick_word()};
   endfunction

   // Probe that usually copies a stored record, sometimes with one field disturbed
   function automatic record_type probe_for_table();
      record_type rec;
      if (table_fill == 0 || $urandom_range(9) < 3) return pick_record();
      rec = table_copy[$urandom_range(table_fill - 1)];
      case ($urandom_range(5))
         0: rec.id = pick_word();
         1: rec.first_value = pick_word();
         2: rec.second_value = pick_word();
         default: ;
      endcase
      return rec;
   endfunction

   // Present one request, hold it until the transfer, then queue its results
   task automatic send_request(input logic [1:0] kind, input record_type rec,
                               input int typed_hits);
      join_row_type hits [$];
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_type            <= kind;
      req_in_id           <= rec.id;
      req_in_first_value  <= rec.first_value;
      req_in_second_value <= rec.second_value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_request(kind, rec, hits);
      // Rows with a typed answer: none, or the probe followed by its identical stored copy
      if (typed_hits != NO_CHECK) begin
         hits.delete();
         if (typed_hits == 1) begin
            hits.push_back(to_row(rec, 1'b0, 1'b0));
            hits.push_back(to_row(rec, 1'b1, 1'b1));
         end
      end
      foreach (hits[i]) rows_due.push_back(hits[i]);
      case (kind)
         REQ_CLEAR:  clears_sent++;
         REQ_APPEND: appends_sent++;
         REQ_PROBE: begin
            probes_sent++;
            if (hits.size() > deepest_probe) deepest_probe = hits.size();
         end
         default:    ignored_sent++;
      endcase
      if (kind != REQ_UNUSED) work_items++;
   endtask

   // Drop valid and hold until every result is back and a scan would have ended
   task automatic wait_until_idle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (rows_due.size() != 0 && guard < DRAIN_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_compare_field(input logic on_second);
      wait_until_idle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= on_second;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      match_on_second = on_second;
   endtask

   // One load-and-probe pass; an overfill pass fills the table with one record
   // and then offers two more appends that must be dropped
   task automatic run_sequence(input bit overfill);
      record_type rec;
      if (overfill || $urandom_range(3) != 0) send_request(REQ_CLEAR, pick_record(), NO_CHECK);
      if (overfill) begin
         rec = pick_record();
         repeat (TABLE_DEPTH) send_request(REQ_APPEND, rec, NO_CHECK);
         repeat (2) send_request(REQ_APPEND, pick_record(), NO_CHECK);
         send_request(REQ_PROBE, rec, NO_CHECK);
      end else begin
         repeat ($urandom_range(0, 12)) send_request(REQ_APPEND, pick_record(), NO_CHECK);
      end
      repeat ($urandom_range(1, 8)) begin
         if ($urandom_range(7) == 0) send_request(REQ_UNUSED, pick_record(), NO_CHECK);
         send_request(REQ_PROBE, probe_for_table(), NO_CHECK);
      end
   endtask

   // Receiver stalls at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Compare each result transfer with the oldest expected row
   always @(posedge clock) begin : check_rsp
      join_row_type seen;
      join_row_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = '{rsp_out_id, rsp_out_first_value, rsp_out_second_value,
                  rsp_out_from_table, rsp_out_last};
         rows_checked++;
         if (rows_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result: %s", row_text(seen));
         end else begin
            want = rows_due.pop_front();
            if (seen !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("result mismatch at %0t", $realtime);
                  $display("  expected %s", row_text(want));
                  $display("  actual   %s", row_text(seen));
               end
            end
         end
      end
   end

   initial begin : stimulus
      script_step_type script [0:SCRIPT_LEN-1];
      int phase_start;

      script = '{
         '{1'b0, REQ_PROBE,  '{32'sd0, 32'sd0, 32'sd0}, 0},            // empty table
         '{1'b0, REQ_UNUSED, '{WORD_ONES, WORD_ONES, WORD_ONES}, 0},
         '{1'b0, REQ_APPEND, '{WORD_MIN, WORD_MAX, 32'sd0}, NO_CHECK},
         '{1'b0, REQ_APPEND, '{WORD_MAX, WORD_MIN, WORD_ONES}, NO_CHECK},
         '{1'b0, REQ_APPEND, '{32'sd0, 32'sd0, 32'sd0}, NO_CHECK},
         '{1'b0, REQ_APPEND, '{WORD_ONES, WORD_ONES, WORD_ONES}, NO_CHECK},
         '{1'b0, REQ_PROBE,  '{WORD_MIN, WORD_MAX, 32'sd0}, 1},
         '{1'b0, REQ_PROBE,  '{WORD_MAX, WORD_MIN, 32'sd5}, NO_CHECK},
         '{1'b0, REQ_PROBE,  '{32'sd0, 32'sd1, 32'sd0}, 0},            // id hits, value misses
         '{1'b0, REQ_PROBE,  '{WORD_ONES, WORD_ONES, WORD_ONES}, 1},
         '{1'b0, REQ_APPEND, '{32'sd0, 32'sd0, 32'sd7}, NO_CHECK},
         '{1'b0, REQ_PROBE,  '{32'sd0, 32'sd0, 32'sd0}, NO_CHECK},     // two matches
         '{1'b1, REQ_CLEAR,  '{32'sd1, 32'sd0, 32'sd0}, NO_CHECK},     // compare second value
         '{1'b0, REQ_PROBE,  '{WORD_MIN, 32'sd42, 32'sd0}, NO_CHECK},
         '{1'b0, REQ_PROBE,  '{32'sd0, 32'sd9, 32'sd7}, NO_CHECK},
         '{1'b0, REQ_PROBE,  '{WORD_ONES, WORD_ONES, WORD_ONES}, 1},
         '{1'b0, REQ_PROBE,  '{WORD_MAX, WORD_MIN, 32'sd5}, 0},
         '{1'b1, REQ_CLEAR,  '{32'sd0, 32'sd0, 32'sd0}, NO_CHECK},     // compare first value
         '{1'b0, REQ_CLEAR,  '{WORD_ONES, WORD_ONES, WORD_ONES}, 0},
         '{1'b0, REQ_PROBE,  '{WORD_ONES, WORD_ONES, WORD_ONES}, 0},   // after clear
         '{1'b0, REQ_APPEND, '{WORD_MAX, WORD_MAX, WORD_MAX}, NO_CHECK},
         '{1'b0, REQ_PROBE,  '{WORD_MAX, WORD_MAX, WORD_MAX}, 1}
      };

      // Known values on every input before the first edge
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_type            <= REQ_CLEAR;
      req_in_id           <= '0;
      req_in_first_value  <= '0;
      req_in_second_value <= '0;
      rsp_ready           <= 1'b0;
      csr_write_enable    <= 1'b0;
      csr_write_data      <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      write_compare_field(1'b0);
      foreach (script[i]) begin
         if (script[i].is_csr) write_compare_field(script[i].rec.id[0]);
         else send_request(script[i].kind, script[i].rec, script[i].typed_hits);
      end

      // Random traffic: no idling, idle sender, stalling receiver, then both
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
            default: begin sender_idle_pct = 17; receiver_stall_pct = 17; end
         endcase
         write_compare_field(~phase[0]);
         phase_start = work_items;
         if (phase == 0 || phase == 2) run_sequence(1'b1);
         while (work_items - phase_start < RANDOM_PER_PHASE) begin
            run_sequence(1'b0);
            // hold off now and then until the block has drained
            if ($urandom_range(9) == 0) wait_until_idle();
         end
      end

      wait_until_idle();
      if (rows_due.size() != 0) begin
         mismatches += rows_due.size();
         $display("%0d expected results never arrived", rows_due.size());
      end

      $display("sent %0d requests: %0d probes, %0d appends, %0d clears, %0d unused codes",
               work_items + ignored_sent, probes_sent, appends_sent, clears_sent, ignored_sent);
      $display("checked %0d results in both compare modes, up to %0d from one probe",
               rows_checked, deepest_probe);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
